/* design/ctgw_pkg.sv */
// shared types, constants and helpers for the causal gqa tile address walker
package ctgw_pkg;

	localparam int MAX_SEQ_TILES = 1024;
	localparam int MAX_DIM_TILES = 16;
	localparam int MAX_HEADS     = 64;
	localparam int ADDR_BITS     = 48;
	localparam int TILE_BYTES    = 32 * 32 * 2;
	localparam int TILE_SHIFT    = $clog2(TILE_BYTES);

	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;

	// partial product widths of the index datapath
	localparam int P1_W  = 17;
	localparam int IDX_W = 29;

	// command queue and result queue depths (powers of two)
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// restoring divider steps for a 7-bit dividend
	localparam int DIV_STEPS = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_Q_BASE      = 3'd0,
		CFG_KT_BASE     = 3'd1,
		CFG_V_BASE      = 3'd2,
		CFG_SEQ_TILES   = 3'd3,
		CFG_DIM_TILES   = 3'd4,
		CFG_QUERY_HEADS = 3'd5,
		CFG_KV_HEADS    = 3'd6
	} ctgw_cfg_idx_t;

	localparam logic [1:0] BUF_QUERY = 2'd0;
	localparam logic [1:0] BUF_KEY   = 2'd1;
	localparam logic [1:0] BUF_VALUE = 2'd2;

	typedef enum logic [2:0] {
		PH_QUERY = 3'b001,
		PH_KEY   = 3'b010,
		PH_VALUE = 3'b100
	} ctgw_phase_t;

	typedef struct packed {
		logic advance;
		logic restart;
	} ctgw_req_t;

	typedef struct packed {
		logic [47:0] read_address;
		logic [1:0]  buffer_id;
		logic        group_last;
		logic        walk_last;
	} ctgw_res_t;

	typedef struct packed {
		logic [47:0] q_base;
		logic [47:0] kt_base;
		logic [47:0] v_base;
		logic [10:0] seq_tiles;
		logic [4:0]  dim_tiles;
		logic [6:0]  query_heads;
		logic [6:0]  kv_heads;
	} ctgw_cfg_t;

	// index = (x * y + z) * w + u
	typedef struct packed {
		logic [9:0]  x;
		logic [6:0]  y;
		logic [6:0]  z;
		logic [10:0] w;
		logic [9:0]  u;
		logic [1:0]  buffer_id;
		logic        group_last;
		logic        walk_last;
	} ctgw_cmd_t;

	typedef struct packed {
		logic       done;
		logic [6:0] quotient;
	} ctgw_div_stat_t;

	function automatic logic [10:0] clamp_seq(input logic [10:0] v);
		logic [10:0] r;
		if (v == 11'd0) r = 11'd1;
		else if (v > 11'(MAX_SEQ_TILES)) r = 11'(MAX_SEQ_TILES);
		else r = v;
		return r;
	endfunction

	function automatic logic [4:0] clamp_dim(input logic [4:0] v);
		logic [4:0] r;
		if (v == 5'd0) r = 5'd1;
		else if (v > 5'(MAX_DIM_TILES)) r = 5'(MAX_DIM_TILES);
		else r = v;
		return r;
	endfunction

	function automatic logic [6:0] clamp_heads(input logic [6:0] v);
		logic [6:0] r;
		if (v == 7'd0) r = 7'd1;
		else if (v > 7'(MAX_HEADS)) r = 7'(MAX_HEADS);
		else r = v;
		return r;
	endfunction

endpackage

/* design/ctgw_div.sv */
// iterative restoring divider for the heads-per-group ratio
module ctgw_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [6:0]              dividend,
	input  logic [6:0]              divisor,
	output ctgw_pkg::ctgw_div_stat_t stat
);
	import ctgw_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic [6:0]       rem_q;
	logic [6:0]       quo_q;
	logic [6:0]       dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [7:0]       rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[6]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 7'(rem_sh - {1'b0, dvs_q}) : rem_sh[6:0];
			quo_q <= {quo_q[5:0], fits};
		end
	end

	assign stat.done     = done_q;
	assign stat.quotient = quo_q;

endmodule

/* design/ctgw_front.sv */
// walk sequencer: accepts requests, advances the loop counters, emits index commands
module ctgw_front (
	input  logic                clk,
	input  logic                arst_n,
	input  ctgw_pkg::ctgw_cfg_t cfg,
	input  logic                push,
	input  ctgw_pkg::ctgw_req_t request,
	output logic                full,
	input  logic                cq_full,
	output logic                cmd_push,
	output ctgw_pkg::ctgw_cmd_t cmd
);
	import ctgw_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_DIV = 2'b10
	} front_state_t;

	front_state_t   state_q;
	ctgw_phase_t    phase_q, n_phase;
	logic [6:0]     head_q, n_head;
	logic [6:0]     kv_q, n_kv;
	logic [6:0]     gpos_q, n_gpos;
	logic [6:0]     hpg_q, hpg_use;
	logic [9:0]     qt_q, n_qt;
	logic [9:0]     kb_q, n_kb;
	logic [4:0]     tig_q, n_tig;
	logic           done_q, n_done;

	logic [10:0]    s_c;
	logic [4:0]     d_c;
	logic [6:0]     nq_c;
	logic [6:0]     nk_c;

	logic           accept;
	logic           at_start;
	logic           go_adv;
	logic           div_start;
	logic           div_finish;
	logic           do_step;
	logic           glast;
	logic           wlast;
	logic [6:0]     gpos_inc;
	ctgw_div_stat_t div_stat;

	assign s_c  = clamp_seq(cfg.seq_tiles);
	assign d_c  = clamp_dim(cfg.dim_tiles);
	assign nq_c = clamp_heads(cfg.query_heads);
	assign nk_c = clamp_heads(cfg.kv_heads);

	assign full     = (state_q != ST_RUN) || cq_full;
	assign accept   = push && !full;
	assign at_start = (head_q == 7'd0) && (qt_q == 10'd0) && (tig_q == 5'd0)
		&& (phase_q == PH_QUERY);
	assign go_adv     = accept && !request.restart && request.advance && !done_q;
	assign div_start  = go_adv && at_start;
	assign div_finish = (state_q == ST_DIV) && div_stat.done && !cq_full;
	assign do_step    = (go_adv && !at_start) || div_finish;
	assign cmd_push   = do_step;

	// group size never drops below one
	assign hpg_use = (state_q == ST_DIV)
		? ((div_stat.quotient == 7'd0) ? 7'd1 : div_stat.quotient) : hpg_q;

	ctgw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nq_c),
		.divisor  (nk_c),
		.stat     (div_stat)
	);

	always_comb begin
		n_phase  = phase_q;
		n_head   = head_q;
		n_kv     = kv_q;
		n_gpos   = gpos_q;
		n_qt     = qt_q;
		n_kb     = kb_q;
		n_tig    = tig_q;
		n_done   = done_q;
		wlast    = 1'b0;
		gpos_inc = 7'(gpos_q + 7'd1);
		glast    = ({1'b0, tig_q} + 6'd1) >= {1'b0, d_c};

		case (phase_q)
			PH_KEY: begin
				cmd.x         = {3'd0, kv_q};
				cmd.y         = {2'd0, d_c};
				cmd.z         = {2'd0, tig_q};
				cmd.w         = s_c;
				cmd.u         = kb_q;
				cmd.buffer_id = BUF_KEY;
			end
			PH_VALUE: begin
				cmd.x         = kb_q;
				cmd.y         = nk_c;
				cmd.z         = kv_q;
				cmd.w         = {6'd0, d_c};
				cmd.u         = {5'd0, tig_q};
				cmd.buffer_id = BUF_VALUE;
			end
			default: begin
				cmd.x         = qt_q;
				cmd.y         = nq_c;
				cmd.z         = head_q;
				cmd.w         = {6'd0, d_c};
				cmd.u         = {5'd0, tig_q};
				cmd.buffer_id = BUF_QUERY;
			end
		endcase

		if (!glast) begin
			n_tig = 5'(tig_q + 5'd1);
		end else begin
			n_tig = 5'd0;
			case (phase_q)
				PH_KEY: begin
					n_phase = PH_VALUE;
				end
				PH_VALUE: begin
					if (kb_q >= qt_q) begin
						n_kb    = 10'd0;
						n_phase = PH_QUERY;
						if (({1'b0, qt_q} + 11'd1) >= s_c) begin
							n_qt = 10'd0;
							if (({1'b0, head_q} + 8'd1) >= {1'b0, nq_c}) begin
								wlast  = 1'b1;
								n_done = 1'b1;
							end else begin
								n_head = 7'(head_q + 7'd1);
								if (gpos_inc >= hpg_use) begin
									n_gpos = 7'd0;
									n_kv   = 7'(kv_q + 7'd1);
								end else begin
									n_gpos = gpos_inc;
								end
							end
						end else begin
							n_qt = 10'(qt_q + 10'd1);
						end
					end else begin
						n_kb    = 10'(kb_q + 10'd1);
						n_phase = PH_KEY;
					end
				end
				default: begin
					n_kb    = 10'd0;
					n_phase = PH_KEY;
				end
			endcase
		end

		cmd.group_last = glast;
		cmd.walk_last  = wlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			phase_q <= PH_QUERY;
			head_q  <= '0;
			kv_q    <= '0;
			gpos_q  <= '0;
			hpg_q   <= '0;
			qt_q    <= '0;
			kb_q    <= '0;
			tig_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (accept && request.restart) begin
				phase_q <= PH_QUERY;
				head_q  <= '0;
				kv_q    <= '0;
				gpos_q  <= '0;
				qt_q    <= '0;
				kb_q    <= '0;
				tig_q   <= '0;
				done_q  <= 1'b0;
			end else if (do_step) begin
				phase_q <= n_phase;
				head_q  <= n_head;
				kv_q    <= n_kv;
				gpos_q  <= n_gpos;
				qt_q    <= n_qt;
				kb_q    <= n_kb;
				tig_q   <= n_tig;
				done_q  <= n_done;
			end
			if (div_start) begin
				state_q <= ST_DIV;
			end else if (div_finish) begin
				state_q <= ST_RUN;
				hpg_q   <= hpg_use;
			end
		end
	end

endmodule

/* design/ctgw_cmd_queue.sv */
// short command queue between the sequencer and the address datapath
module ctgw_cmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ctgw_pkg::ctgw_cmd_t wdata,
	output logic                full,
	input  logic                pop,
	output ctgw_pkg::ctgw_cmd_t rdata,
	output logic                empty
);
	import ctgw_pkg::*;

	ctgw_cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0]   wr_ptr_q;
	logic [CQ_PTR_W-1:0]   rd_ptr_q;
	logic [CQ_CNT_W-1:0]   cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = cnt_q == CQ_CNT_W'(CQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

/* design/ctgw_back.sv */
// address datapath: two multiply stages, base add and result queue
module ctgw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ctgw_pkg::ctgw_cfg_t cfg,
	input  logic                cq_empty,
	input  ctgw_pkg::ctgw_cmd_t cq_head,
	output logic                cq_pop,
	output ctgw_pkg::ctgw_res_t result,
	output logic                empty,
	input  logic                pop
);
	import ctgw_pkg::*;

	typedef struct packed {
		logic [1:0] buffer_id;
		logic       group_last;
		logic       walk_last;
	} back_tag_t;

	logic                v_s1, v_s2;
	logic [P1_W-1:0]     p1_s1;
	logic [10:0]         w_s1;
	logic [9:0]          u_s1;
	back_tag_t           tag_s1, tag_s2;
	logic [IDX_W-1:0]    idx_s2;

	logic [OQ_CNT_W-1:0] credit_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	ctgw_res_t           mem_q [OQ_DEPTH];

	logic                take;
	logic                out_pop;
	logic [P1_W-1:0]     p1_d;
	logic [IDX_W-1:0]    idx_d;
	logic [47:0]         base_sel;
	ctgw_res_t           res_d;

	// credits cover words in the pipeline plus words in the result queue
	assign take    = !cq_empty && (credit_q != OQ_CNT_W'(OQ_DEPTH));
	assign cq_pop  = take;
	assign out_pop = pop && !empty;

	assign p1_d  = P1_W'(cq_head.x) * P1_W'(cq_head.y) + P1_W'(cq_head.z);
	assign idx_d = IDX_W'(p1_s1) * IDX_W'(w_s1) + IDX_W'(u_s1);

	always_comb begin
		case (tag_s2.buffer_id)
			BUF_KEY:   base_sel = cfg.kt_base;
			BUF_VALUE: base_sel = cfg.v_base;
			default:   base_sel = cfg.q_base;
		endcase
		res_d.read_address = 48'(base_sel + (48'(idx_s2) << TILE_SHIFT));
		res_d.buffer_id    = tag_s2.buffer_id;
		res_d.group_last   = tag_s2.group_last;
		res_d.walk_last    = tag_s2.walk_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			credit_q <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (take && !out_pop) credit_q <= credit_q + 1'b1;
			else if (out_pop && !take) credit_q <= credit_q - 1'b1;
			if (v_s2) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (out_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (v_s2 && !out_pop) cnt_q <= cnt_q + 1'b1;
			else if (out_pop && !v_s2) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1  <= p1_d;
		w_s1   <= cq_head.w;
		u_s1   <= cq_head.u;
		tag_s1 <= '{cq_head.buffer_id, cq_head.group_last, cq_head.walk_last};
		idx_s2 <= idx_d;
		tag_s2 <= tag_s1;
		if (v_s2) mem_q[wr_ptr_q] <= res_d;
	end

	assign empty  = cnt_q == '0;
	assign result = mem_q[rd_ptr_q];

endmodule

/* design/causal_gqa_tile_address_walker.sv */
// top level of the causal gqa tile address walker
// path: a result word passes the command queue, the two multiply stages and the result queue;
//   the first advance of a walk runs the 7-step group-size divide ahead of that
// throughput: one request per cycle while the command queue has room; the divide stalls
//   the request side once per walk
// reset: arst_n clears the walk, queues and config (bases 0, sizes 1) at once
module causal_gqa_tile_address_walker (
	input  logic                              clk,
	input  logic                              arst_n,
	// request side
	input  logic                              push,
	input  ctgw_pkg::ctgw_req_t               request,
	output logic                              full,
	// result side
	output ctgw_pkg::ctgw_res_t               result,
	output logic                              empty,
	input  logic                              pop,
	// config write port
	input  logic                              cfg_wr_en,
	input  logic [ctgw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ctgw_pkg::CFG_W-1:0]        cfg_data
);
	import ctgw_pkg::*;

	ctgw_cfg_t cfg_q;
	logic      cq_push;
	ctgw_cmd_t cq_wdata;
	logic      cq_full;
	logic      cq_pop;
	ctgw_cmd_t cq_rdata;
	logic      cq_empty;

	// config registers, sizes are clamped where they are used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.q_base      <= '0;
			cfg_q.kt_base     <= '0;
			cfg_q.v_base      <= '0;
			cfg_q.seq_tiles   <= 11'd1;
			cfg_q.dim_tiles   <= 5'd1;
			cfg_q.query_heads <= 7'd1;
			cfg_q.kv_heads    <= 7'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_Q_BASE:      cfg_q.q_base      <= cfg_data[47:0];
				CFG_KT_BASE:     cfg_q.kt_base     <= cfg_data[47:0];
				CFG_V_BASE:      cfg_q.v_base      <= cfg_data[47:0];
				CFG_SEQ_TILES:   cfg_q.seq_tiles   <= cfg_data[10:0];
				CFG_DIM_TILES:   cfg_q.dim_tiles   <= cfg_data[4:0];
				CFG_QUERY_HEADS: cfg_q.query_heads <= cfg_data[6:0];
				CFG_KV_HEADS:    cfg_q.kv_heads    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// front: loop counters over head, query tile, key block and tile in group;
	// a word that yields an address leaves here as an index command
	ctgw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.request  (request),
		.full     (full),
		.cq_full  (cq_full),
		.cmd_push (cq_push),
		.cmd      (cq_wdata)
	);

	// decouples the sequencer from the multiply pipeline
	ctgw_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cq_wdata),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.empty  (cq_empty)
	);

	// back: index = (x*y + z)*w + u in two registered steps, then
	// base + index * tile bytes into the result queue
	ctgw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cq_empty (cq_empty),
		.cq_head  (cq_rdata),
		.cq_pop   (cq_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

/* design/ctgw_checker.sv */
// port-level checks for the causal gqa tile address walker
module ctgw_checker (
	input logic                clk,
	input logic                arst_n,
	input ctgw_pkg::ctgw_res_t result,
	input logic                empty,
	input logic                pop
);
	import ctgw_pkg::*;

	// buffer code is one of the three buffers
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.buffer_id == BUF_QUERY || result.buffer_id == BUF_KEY
			|| result.buffer_id == BUF_VALUE))
		else $error("bad buffer id");

	// the walk ends on the closing tile of a group
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.walk_last) |-> result.group_last)
		else $error("walk end not on group end");

	// the walk ends on a value tile
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.walk_last) |-> (result.buffer_id == BUF_VALUE))
		else $error("walk end not on value buffer");

	// a waiting word holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting word changed");

endmodule

bind causal_gqa_tile_address_walker ctgw_checker u_ctgw_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench for the causal gqa tile address walker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ctgw_pkg::*;

	// register index with no register behind it, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam logic [7:0] ALL_REGS = 8'hFF;

	// the four request words
	localparam ctgw_req_t WORD_ADVANCE = '{advance: 1'b1, restart: 1'b0};
	localparam ctgw_req_t WORD_RESTART = '{advance: 1'b0, restart: 1'b1};
	localparam ctgw_req_t WORD_IDLE    = '{advance: 1'b0, restart: 1'b0};
	localparam ctgw_req_t WORD_BOTH    = '{advance: 1'b1, restart: 1'b1};

	// covers the pipeline and the divide on the first advance of a walk; leave margin
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_WORDS  = 600;
	localparam int MAX_ERR_LINES = 100;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	ctgw_req_t request = '0;
	logic full;
	ctgw_res_t result;
	logic empty;
	logic pop = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	causal_gqa_tile_address_walker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.request(request),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the register file, reset values: bases 0, sizes 1
	ctgw_cfg_t shadow = '{q_base: '0, kt_base: '0, v_base: '0, seq_tiles: 11'd1,
		dim_tiles: 5'd1, query_heads: 7'd1, kv_heads: 7'd1};

	// shadow walk state
	logic [6:0] w_head = '0;
	logic [6:0] w_kv = '0;
	logic [6:0] w_grp_pos = '0;
	logic [6:0] w_hpg = '0;
	logic [9:0] w_qtile = '0;
	logic [9:0] w_kblock = '0;
	logic [4:0] w_tile = '0;
	ctgw_phase_t w_phase = PH_QUERY;
	logic w_done = 1'b0;

	// tile addresses predicted but not yet popped, oldest first
	ctgw_res_t pending_tiles[$];

	// register values staged for the next programming pass
	logic [47:0] plan_data [8];

	int n_errors = 0;
	int walk_items = 0;  // every accepted request word
	bit no_idle = 1'b0;
	int pop_gap = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_error(input string what);
		n_errors++;
		if (n_errors <= MAX_ERR_LINES)
			$display("ERROR %0t: %s", $time, what);
	endtask

	function automatic int unsigned sat_size(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void latch_group();
		int unsigned ratio;
		ratio = sat_size(shadow.query_heads, MAX_HEADS) / sat_size(shadow.kv_heads, MAX_HEADS);
		w_hpg = (ratio == 0) ? 7'd1 : 7'(ratio);
	endfunction

	function automatic void clear_walk();
		w_head = '0;
		w_kv = '0;
		w_grp_pos = '0;
		w_qtile = '0;
		w_kblock = '0;
		w_tile = '0;
		w_phase = PH_QUERY;
		w_done = 1'b0;
	endfunction

	function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
		case (idx)
		CFG_Q_BASE:      shadow.q_base = data;
		CFG_KT_BASE:     shadow.kt_base = data;
		CFG_V_BASE:      shadow.v_base = data;
		CFG_SEQ_TILES:   shadow.seq_tiles = data[10:0];
		CFG_DIM_TILES:   shadow.dim_tiles = data[4:0];
		CFG_QUERY_HEADS: shadow.query_heads = data[6:0];
		CFG_KV_HEADS:    shadow.kv_heads = data[6:0];
		default: ;
		endcase
	endfunction

	// one accepted request word: moves the shadow walk and queues the tile it yields
	function automatic void advance_walker(input ctgw_req_t req);
		int unsigned s_eff, d_eff, nq_eff, nk_eff;
		longint unsigned tile_no, base;
		ctgw_res_t word;
		walk_items++;
		if (req.restart) begin
			// restart beats advance and never yields a word
			clear_walk();
			latch_group();
			return;
		end
		if (!req.advance || w_done)
			return;
		// group size is taken again when the walk sits at its very first address
		if (w_head == 0 && w_qtile == 0 && w_tile == 0 && w_phase == PH_QUERY)
			latch_group();
		// sizes are read live, zero counts as one, oversize saturates
		s_eff = sat_size(shadow.seq_tiles, MAX_SEQ_TILES);
		d_eff = sat_size(shadow.dim_tiles, MAX_DIM_TILES);
		nq_eff = sat_size(shadow.query_heads, MAX_HEADS);
		nk_eff = sat_size(shadow.kv_heads, MAX_HEADS);
		word.group_last = (w_tile + 1 >= d_eff);
		word.walk_last = 1'b0;
		case (w_phase)
		PH_KEY: begin
			word.buffer_id = BUF_KEY;
			base = shadow.kt_base;
			tile_no = w_kv;
			tile_no = (tile_no * d_eff + w_tile) * s_eff + w_kblock;
		end
		PH_VALUE: begin
			word.buffer_id = BUF_VALUE;
			base = shadow.v_base;
			tile_no = w_kblock;
			tile_no = tile_no * nk_eff * d_eff + longint'(w_kv) * d_eff + w_tile;
		end
		default: begin
			word.buffer_id = BUF_QUERY;
			base = shadow.q_base;
			tile_no = w_qtile;
			tile_no = tile_no * nq_eff * d_eff + longint'(w_head) * d_eff + w_tile;
		end
		endcase
		if (!word.group_last) begin
			w_tile = w_tile + 1'b1;
		end else begin
			w_tile = '0;
			case (w_phase)
			PH_KEY: begin
				w_phase = PH_VALUE;
			end
			PH_VALUE: begin
				if (w_kblock >= w_qtile) begin
					// causal limit reached, next query tile or next head
					w_kblock = '0;
					w_phase = PH_QUERY;
					if (w_qtile + 1 >= s_eff) begin
						w_qtile = '0;
						if (w_head + 1 >= nq_eff) begin
							word.walk_last = 1'b1;
							w_done = 1'b1;
						end else begin
							w_head = w_head + 1'b1;
							// running kv counter, keeps counting on uneven groups
							w_grp_pos = w_grp_pos + 1'b1;
							if (w_grp_pos >= w_hpg) begin
								w_grp_pos = '0;
								w_kv = w_kv + 1'b1;
							end
						end
					end else begin
						w_qtile = w_qtile + 1'b1;
					end
				end else begin
					w_kblock = w_kblock + 1'b1;
					w_phase = PH_KEY;
				end
			end
			default: begin
				w_kblock = '0;
				w_phase = PH_KEY;
			end
			endcase
		end
		// wraps at the address width
		word.read_address = 48'(base + tile_no * TILE_BYTES);
		pending_tiles.push_back(word);
	endfunction

	// request side monitor, feeds the shadow walker
	always @(posedge clk) begin
		if (arst_n && push && !full)
			advance_walker(request);
	end

	// result side: random pop stalls in short bursts, none near the end
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (no_idle) begin
			pop <= 1'b1;
		end else if (pop_gap > 0) begin
			pop <= 1'b0;
			pop_gap--;
		end else if ($urandom_range(0, 5) == 0) begin
			pop <= 1'b0;
			pop_gap = $urandom_range(0, 2);
		end else begin
			pop <= 1'b1;
		end
	end

	// every popped word against the oldest prediction
	always @(posedge clk) begin : check_tiles
		ctgw_res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_tiles.size() == 0) begin
				report_error($sformatf("unexpected word addr %h buf %0d", result.read_address,
					result.buffer_id));
			end else begin
				want = pending_tiles.pop_front();
				if (result.read_address !== want.read_address)
					report_error($sformatf("read_address got %h want %h",
						result.read_address, want.read_address));
				if (result.buffer_id !== want.buffer_id)
					report_error($sformatf("buffer_id got %0d want %0d (addr %h)",
						result.buffer_id, want.buffer_id, want.read_address));
				if (result.group_last !== want.group_last)
					report_error($sformatf("group_last got %b want %b (addr %h)",
						result.group_last, want.group_last, want.read_address));
				if (result.walk_last !== want.walk_last)
					report_error($sformatf("walk_last got %b want %b (addr %h)",
						result.walk_last, want.walk_last, want.read_address));
			end
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [47:0] pick_base();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '1;
		if (r == 1)
			return '0;
		return rand48();
	endfunction

	// size value, now and then with junk above the register width
	function automatic logic [47:0] size_word(input int unsigned v, input int keep);
		if ($urandom_range(0, 5) == 0)
			return (rand48() << keep) | 48'(v);
		return 48'(v);
	endfunction

	// one request word, with an optional idle burst ahead of it
	task automatic send_word(input ctgw_req_t req);
		int gap;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		request <= req;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_words(input ctgw_req_t req, input int n);
		repeat (n)
			send_word(req);
	endtask

	// wait for every predicted word, then let no-result words clear the pipe
	task automatic drain();
		push <= 1'b0;
		while (pending_tiles.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes the staged values of the selected registers, one per cycle
	task automatic program_regs(input logic [7:0] sel);
		for (int i = 0; i < 8; i++) begin
			if (sel[i]) begin
				cfg_wr_en <= 1'b1;
				cfg_index <= CFG_IDX_W'(i);
				cfg_data <= plan_data[i];
				@(posedge clk);
				shadow_write(CFG_IDX_W'(i), plan_data[i]);
			end
		end
		cfg_wr_en <= 1'b0;
	endtask

	// reset config: one head, one tile, so query, key, value and done
	task automatic test_default_walk();
		send_words(WORD_ADVANCE, 3);
		// finished walk ignores advances, idle word does nothing
		send_word(WORD_ADVANCE);
		send_word(WORD_IDLE);
		// restart wins over a simultaneous advance
		send_word(WORD_BOTH);
		drain();
	endtask

	// saturating sizes, all-ones bases that wrap, then a shrink mid walk
	task automatic test_extreme_sizes();
		logic [7:0] sel;
		plan_data[CFG_Q_BASE] = '1;
		plan_data[CFG_KT_BASE] = '1;
		plan_data[CFG_V_BASE] = '1;
		plan_data[CFG_SEQ_TILES] = 48'd2047;
		plan_data[CFG_DIM_TILES] = 48'd31;
		plan_data[CFG_QUERY_HEADS] = 48'd127;
		plan_data[CFG_KV_HEADS] = 48'd0;
		plan_data[CFG_SPARE] = rand48();
		program_regs(ALL_REGS);
		send_word(WORD_RESTART);
		send_words(WORD_ADVANCE, 3);
		drain();
		// dim_tiles drops to one with junk high bits, group ends at once
		plan_data[CFG_DIM_TILES] = (rand48() & ~48'h1F) | 48'd1;
		sel = '0;
		sel[CFG_DIM_TILES] = 1'b1;
		program_regs(sel);
		send_words(WORD_ADVANCE, 2);
		drain();
	endtask

	// zero sizes count as one; more kv heads than query heads
	task automatic test_zero_sizes();
		plan_data[CFG_Q_BASE] = rand48();
		plan_data[CFG_KT_BASE] = rand48();
		plan_data[CFG_V_BASE] = rand48();
		plan_data[CFG_SEQ_TILES] = '0;
		plan_data[CFG_DIM_TILES] = '0;
		plan_data[CFG_QUERY_HEADS] = '0;
		plan_data[CFG_KV_HEADS] = 48'd127;
		program_regs(8'h7F);
		send_word(WORD_RESTART);
		send_words(WORD_ADVANCE, 4);
		drain();
	endtask

	// three query heads over two kv heads, last head runs past kv_heads
	task automatic test_uneven_groups();
		logic [7:0] sel;
		plan_data[CFG_SEQ_TILES] = 48'd1;
		plan_data[CFG_DIM_TILES] = 48'd1;
		plan_data[CFG_QUERY_HEADS] = 48'd3;
		plan_data[CFG_KV_HEADS] = 48'd2;
		sel = '0;
		sel[CFG_SEQ_TILES] = 1'b1;
		sel[CFG_DIM_TILES] = 1'b1;
		sel[CFG_QUERY_HEADS] = 1'b1;
		sel[CFG_KV_HEADS] = 1'b1;
		program_regs(sel);
		send_word(WORD_RESTART);
		send_words(WORD_ADVANCE, 9);
		drain();
	endtask

	task automatic plan_random_config();
		int unsigned nq, kv;
		plan_data[CFG_Q_BASE] = pick_base();
		plan_data[CFG_KT_BASE] = pick_base();
		plan_data[CFG_V_BASE] = pick_base();
		plan_data[CFG_SPARE] = rand48();
		if ($urandom_range(0, 7) != 0) begin
			// small shapes so walks run to their end
			nq = $urandom_range(1, 4);
			kv = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : $urandom_range(1, nq);
			plan_data[CFG_SEQ_TILES] = size_word($urandom_range(1, 3), 11);
			plan_data[CFG_DIM_TILES] = size_word($urandom_range(1, 2), 5);
			plan_data[CFG_QUERY_HEADS] = size_word(nq, 7);
			plan_data[CFG_KV_HEADS] = size_word(kv, 7);
		end else begin
			// zero, max, oversized and arbitrary sizes
			case ($urandom_range(0, 3))
			0: plan_data[CFG_SEQ_TILES] = 48'd0;
			1: plan_data[CFG_SEQ_TILES] = 48'(MAX_SEQ_TILES);
			2: plan_data[CFG_SEQ_TILES] = 48'd2047;
			default: plan_data[CFG_SEQ_TILES] = rand48();
			endcase
			case ($urandom_range(0, 3))
			0: plan_data[CFG_DIM_TILES] = 48'd0;
			1: plan_data[CFG_DIM_TILES] = 48'(MAX_DIM_TILES);
			2: plan_data[CFG_DIM_TILES] = 48'd31;
			default: plan_data[CFG_DIM_TILES] = rand48();
			endcase
			plan_data[CFG_QUERY_HEADS] = ($urandom_range(0, 1) == 0) ? 48'd127 : rand48();
			plan_data[CFG_KV_HEADS] = ($urandom_range(0, 2) == 0) ? 48'd0 : rand48();
		end
	endtask

	// random phases: mostly clean advance streams, some noise and broken walks
	task automatic test_random_walks();
		int n, k, cap;
		logic [7:0] sel;
		while (walk_items < RANDOM_WORDS) begin
			if (walk_items > RANDOM_WORDS * 4 / 5)
				no_idle = 1'b1;
			plan_random_config();
			// a partial write leaves the walk running under new sizes
			sel = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : ALL_REGS;
			program_regs(sel);
			if ($urandom_range(0, 6) != 0)
				send_word(WORD_RESTART);
			if ($urandom_range(0, 2) == 0) begin
				// run the walk out to its last word
				cap = 150;
				while (!w_done && cap > 0) begin
					send_word(WORD_ADVANCE);
					cap--;
				end
				send_word(WORD_ADVANCE);
			end else begin
				n = $urandom_range(10, 60);
				repeat (n) begin
					k = $urandom_range(0, 99);
					if (k < 86)
						send_word(WORD_ADVANCE);
					else if (k < 92)
						send_word(WORD_IDLE);
					else if (k < 96)
						send_word(WORD_RESTART);
					else
						send_word(WORD_BOTH);
				end
			end
			drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_walk();
		test_extreme_sizes();
		test_zero_sizes();
		test_uneven_groups();
		test_random_walks();
		drain();
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
